[rtl/smx_pkg.sv]
package smx_pkg;

  localparam int MAX_CH_DEF = 64;
  localparam int SCORE_W    = 16;
  localparam int PROB_W     = 16;
  localparam int CCNT_W     = 7;
  localparam int K_W        = 13;
  localparam int K_MAX      = 4096;
  localparam int E_W        = 17;
  localparam int ACC_W      = 64;
  localparam int QUO_W      = 33;
  localparam int EXP_BITS   = 13;

  localparam logic [ACC_W-1:0] Q62_ONE = 64'h4000_0000_0000_0000;

  typedef enum logic [3:0] {
    B_IDLE, B_RD, B_SUB, B_BIT, B_MUL, B_FIN, D_RD, D_INIT, D_STEP, D_OUT
  } back_state_t;

  typedef struct packed {
    logic [SCORE_W-1:0] max;
    logic [CCNT_W-1:0]  n;
    logic               bank;
  } col_desc_t;

  typedef struct packed {
    logic               en;
    logic               bank;
    logic [CCNT_W-1:0]  slot;
    logic [SCORE_W-1:0] data;
  } score_wr_t;

  // Truncated Q2.62 product, evaluated only for constants.
  function automatic logic [ACC_W-1:0] mul_q62(logic [ACC_W-1:0] a, logic [ACC_W-1:0] b);
    logic [2*ACC_W-1:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // exp(-1/256) by the alternating Taylor series to order ten.
  function automatic logic [ACC_W-1:0] exp_base();
    logic [ACC_W-1:0] s;
    logic [ACC_W-1:0] t;
    s = Q62_ONE;
    t = Q62_ONE;
    t = (t >> 8) / 1;  s = s - t;
    t = (t >> 8) / 2;  s = s + t;
    t = (t >> 8) / 3;  s = s - t;
    t = (t >> 8) / 4;  s = s + t;
    t = (t >> 8) / 5;  s = s - t;
    t = (t >> 8) / 6;  s = s + t;
    t = (t >> 8) / 7;  s = s - t;
    t = (t >> 8) / 8;  s = s + t;
    t = (t >> 8) / 9;  s = s - t;
    t = (t >> 8) / 10; s = s + t;
    return s;
  endfunction

  // Base raised to 2^i by repeated truncated squaring.
  function automatic logic [ACC_W-1:0] exp_pow(int i);
    logic [ACC_W-1:0] b;
    b = exp_base();
    for (int j = 0; j < i; j++) begin
      b = mul_q62(b, b);
    end
    return b;
  endfunction

  localparam logic [ACC_W-1:0] EXP_POW [16] = '{
    exp_pow(0), exp_pow(1), exp_pow(2), exp_pow(3), exp_pow(4), exp_pow(5),
    exp_pow(6), exp_pow(7), exp_pow(8), exp_pow(9), exp_pow(10), exp_pow(11),
    exp_pow(12), 64'd0, 64'd0, 64'd0
  };

endpackage

[rtl/smx_if.sv]
interface smx_in_if;
  logic                        valid;
  logic                        ready;
  logic signed [15:0]          score;
  modport source (output valid, output score, input ready);
  modport sink (input valid, input score, output ready);
endinterface

interface smx_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] probability;
  logic        column_end;
  modport source (output valid, output probability, output column_end, input ready);
  modport sink (input valid, input probability, input column_end, output ready);
endinterface

interface smx_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] channel_count;
  modport source (output valid, output channel_count, input ready);
  modport sink (input valid, input channel_count, output ready);
endinterface

[rtl/smx_front.sv]
module smx_front #(
  parameter int MAX_CHANNELS = smx_pkg::MAX_CH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  smx_in_if.sink               in_ch,
  smx_cfg_if.sink              cfg_ch,
  input  logic                 q_full,
  output logic                 q_push,
  output smx_pkg::col_desc_t   q_data,
  output smx_pkg::score_wr_t   wr
);
  import smx_pkg::*;

  logic [CCNT_W-1:0]  cc_r, cc_nxt;
  logic [CCNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SCORE_W-1:0] max_r, max_nxt;
  logic               bank_r, bank_nxt;
  logic [CCNT_W-1:0]  n_eff;
  logic [SCORE_W-1:0] new_max;
  logic               acc_in;
  logic               last;

  assign in_ch.ready  = !q_full;
  assign cfg_ch.ready = 1'b1;
  assign acc_in = in_ch.valid && in_ch.ready;

  always_comb begin
    priority if (cc_r == '0) begin
      n_eff = CCNT_W'(1);
    end else if (cc_r > CCNT_W'(MAX_CHANNELS)) begin
      n_eff = CCNT_W'(MAX_CHANNELS);
    end else begin
      n_eff = cc_r;
    end
  end

  assign new_max = ($signed(in_ch.score) > $signed(max_r)) ? in_ch.score : max_r;
  assign last    = (cnt_r + CCNT_W'(1)) == n_eff;

  assign wr.en   = acc_in;
  assign wr.bank = bank_r;
  assign wr.slot = cnt_r;
  assign wr.data = in_ch.score;

  assign q_push      = acc_in && last;
  assign q_data.max  = new_max;
  assign q_data.n    = n_eff;
  assign q_data.bank = bank_r;

  always_comb begin
    cc_nxt   = cc_r;
    cnt_nxt  = cnt_r;
    max_nxt  = max_r;
    bank_nxt = bank_r;
    if (cfg_ch.valid) begin
      // A new count drops any partial column.
      cc_nxt  = cfg_ch.channel_count;
      cnt_nxt = '0;
      max_nxt = 16'h8000;
    end else if (acc_in) begin
      if (last) begin
        cnt_nxt  = '0;
        max_nxt  = 16'h8000;
        bank_nxt = !bank_r;
      end else begin
        cnt_nxt = cnt_r + CCNT_W'(1);
        max_nxt = new_max;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r   <= CCNT_W'(64);
      cnt_r  <= '0;
      max_r  <= 16'h8000;
      bank_r <= 1'b0;
    end else begin
      cc_r   <= cc_nxt;
      cnt_r  <= cnt_nxt;
      max_r  <= max_nxt;
      bank_r <= bank_nxt;
    end
  end

endmodule

[rtl/smx_queue.sv]
module smx_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  smx_pkg::col_desc_t push_data,
  output logic               full,
  output logic               valid,
  output smx_pkg::col_desc_t head,
  input  logic               pop
);
  import smx_pkg::*;

  col_desc_t  ent_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = cnt_r == 2'd2;
  assign valid = cnt_r != 2'd0;
  assign head  = ent_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r ^ push;
    rd_nxt  = rd_r ^ pop;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push || pop) else $error("column queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> valid) else $error("column queue underflow");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 2'd1) else $error("queue count slip");

endmodule

[rtl/smx_back.sv]
module smx_back #(
  parameter int MAX_CHANNELS = smx_pkg::MAX_CH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  smx_pkg::score_wr_t wr,
  input  logic               q_valid,
  input  smx_pkg::col_desc_t q_head,
  output logic               q_pop,
  smx_out_if.source          out_ch
);
  import smx_pkg::*;

  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SUM_W = $clog2(MAX_CHANNELS * 65536 + 1);

  logic [SCORE_W-1:0] score_mem [2**(IDX_W+1)];
  logic [E_W-1:0]     e_mem [MAX_CHANNELS];
  logic [SCORE_W-1:0] score_rd_r;
  logic [E_W-1:0]     e_rd_r;

  back_state_t        st_r, st_nxt;
  col_desc_t          cur_r, cur_nxt;
  logic [CCNT_W-1:0]  ch_r, ch_nxt;
  logic [K_W-1:0]     k_r, k_nxt;
  logic [3:0]         bit_r, bit_nxt;
  logic [2:0]         ph_r, ph_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [2*ACC_W-1:0] prod_r, prod_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [QUO_W-1:0]   num_r, num_nxt;
  logic [QUO_W-1:0]   quo_r, quo_nxt;
  logic [SUM_W:0]     rem_r, rem_nxt;
  logic [5:0]         step_r, step_nxt;
  logic               ov_r, ov_nxt;
  logic [PROB_W-1:0]  prob_r, prob_nxt;
  logic               end_r, end_nxt;

  logic [IDX_W-1:0]   idx;
  logic               ch_last;
  logic [ACC_W-1:0]   mb;
  logic [31:0]        ma, mbh;
  logic [63:0]        pp;
  logic [2*ACC_W-1:0] pp_sh;
  logic signed [16:0] d;
  logic [16:0]        kk;
  logic [ACC_W-1:0]   rnd;
  logic [E_W-1:0]     e_val;
  logic               e_wen;
  logic [SUM_W:0]     rem_sh;
  logic               ge;

  assign idx     = ch_r[IDX_W-1:0];
  assign ch_last = (ch_r + CCNT_W'(1)) == cur_r.n;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      score_mem[{wr.bank, wr.slot[IDX_W-1:0]}] <= wr.data;
    end
    score_rd_r <= score_mem[{cur_r.bank, idx}];
  end

  always_ff @(posedge clk) begin
    if (e_wen) begin
      e_mem[idx] <= e_val;
    end
    e_rd_r <= e_mem[idx];
  end

  // One 32x32 partial product of the Q2.62 multiply per phase.
  always_comb begin
    mb  = EXP_POW[bit_r];
    ma  = (ph_r == 3'd2 || ph_r == 3'd3) ? acc_r[63:32] : acc_r[31:0];
    mbh = (ph_r == 3'd1 || ph_r == 3'd3) ? mb[63:32] : mb[31:0];
    pp  = {32'd0, ma} * {32'd0, mbh};
    unique case (ph_r)
      3'd0:    pp_sh = {64'd0, pp};
      3'd1,
      3'd2:    pp_sh = {32'd0, pp, 32'd0};
      3'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = '0;
    endcase
  end

  assign d      = 17'(signed'(score_rd_r)) - 17'(signed'(cur_r.max));
  assign kk     = 17'(-d);
  assign rnd    = acc_r + (64'd1 << 45);
  assign e_val  = rnd[62:46];
  assign rem_sh = {rem_r[SUM_W-1:0], num_r[QUO_W-1]};
  assign ge     = rem_sh >= {1'b0, sum_r};

  always_comb begin
    st_nxt   = st_r;
    cur_nxt  = cur_r;
    ch_nxt   = ch_r;
    k_nxt    = k_r;
    bit_nxt  = bit_r;
    ph_nxt   = ph_r;
    acc_nxt  = acc_r;
    prod_nxt = prod_r;
    sum_nxt  = sum_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    ov_nxt   = ov_r && !out_ch.ready;
    prob_nxt = prob_r;
    end_nxt  = end_r;
    q_pop    = 1'b0;
    e_wen    = 1'b0;
    unique case (st_r)
      B_IDLE: begin
        if (q_valid) begin
          cur_nxt = q_head;
          ch_nxt  = '0;
          sum_nxt = '0;
          st_nxt  = B_RD;
        end
      end
      B_RD: st_nxt = B_SUB;
      B_SUB: begin
        k_nxt   = (kk > 17'(K_MAX)) ? K_W'(K_MAX) : kk[K_W-1:0];
        acc_nxt = Q62_ONE;
        bit_nxt = '0;
        st_nxt  = B_BIT;
      end
      B_BIT: begin
        priority if (bit_r == 4'(EXP_BITS)) begin
          st_nxt = B_FIN;
        end else if (k_r[bit_r]) begin
          ph_nxt   = '0;
          prod_nxt = '0;
          st_nxt   = B_MUL;
        end else begin
          bit_nxt = bit_r + 4'd1;
        end
      end
      B_MUL: begin
        if (ph_r == 3'd4) begin
          acc_nxt = prod_r[125:62];
          bit_nxt = bit_r + 4'd1;
          st_nxt  = B_BIT;
        end else begin
          prod_nxt = prod_r + pp_sh;
          ph_nxt   = ph_r + 3'd1;
        end
      end
      B_FIN: begin
        e_wen   = 1'b1;
        sum_nxt = sum_r + SUM_W'(e_val);
        if (ch_last) begin
          q_pop  = 1'b1;
          ch_nxt = '0;
          st_nxt = D_RD;
        end else begin
          ch_nxt = ch_r + CCNT_W'(1);
          st_nxt = B_RD;
        end
      end
      D_RD: st_nxt = D_INIT;
      D_INIT: begin
        num_nxt  = {e_rd_r, 16'd0};
        quo_nxt  = '0;
        rem_nxt  = '0;
        step_nxt = '0;
        st_nxt   = D_STEP;
      end
      D_STEP: begin
        num_nxt  = {num_r[QUO_W-2:0], 1'b0};
        quo_nxt  = {quo_r[QUO_W-2:0], ge};
        rem_nxt  = ge ? (rem_sh - {1'b0, sum_r}) : rem_sh;
        step_nxt = step_r + 6'd1;
        if (step_r == 6'(QUO_W - 1)) begin
          st_nxt = D_OUT;
        end
      end
      D_OUT: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt = 1'b1;
          priority if (sum_r == '0) begin
            prob_nxt = '0;
          end else if (quo_r[QUO_W-1:PROB_W] != '0) begin
            prob_nxt = '1;
          end else begin
            prob_nxt = quo_r[PROB_W-1:0];
          end
          end_nxt = ch_last;
          if (ch_last) begin
            st_nxt = B_IDLE;
          end else begin
            ch_nxt = ch_r + CCNT_W'(1);
            st_nxt = D_RD;
          end
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    ch_r   <= ch_nxt;
    k_r    <= k_nxt;
    bit_r  <= bit_nxt;
    ph_r   <= ph_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
    sum_r  <= sum_nxt;
    num_r  <= num_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    prob_r <= prob_nxt;
    end_r  <= end_nxt;
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.probability = prob_r;
  assign out_ch.column_end  = end_r;

  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == B_BIT |-> k_r <= K_W'(K_MAX)) else $error("exponent index out of range");
  a_e_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == B_FIN |-> e_val <= E_W'(65536)) else $error("exponential above one");
  a_sum_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == D_STEP |-> sum_r != '0) else $error("zero sum in divide");
  a_pop_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> st_r == B_FIN && ch_last) else $error("queue popped mid pass");

endmodule

[rtl/softmax_over_channels_core.sv]
// Softmax over the channels of a column, Q8.8 scores in, Q0.16 probabilities out.
// in_ch carries one signed score per word; channel_count words make a column.
// cfg_ch writes channel_count (0 acts as 1, above MAX_CHANNELS as MAX_CHANNELS);
// a write drops any partial column and must be issued only while the block is idle.
// out_ch gives one probability per channel in channel order, column_end set on
// the last one, once the whole column has been loaded.
// The front takes a score every cycle into one of two score banks, so the next
// column loads while the back works; it holds in_ch ready low when both banks wait.
// Per channel the back computes the exponential by stepping through the bits of k
// (k = clamped max - score, one 32x32 partial product a cycle) and runs the
// normalizing division (one quotient bit a cycle). The first output of a column
// follows the whole exponential pass over that column plus one division.
// A stalled out_ch holds its word in the output register and the back waits.
// Reset sets channel_count to 64 and empties the column queue; no memory is
// cleared.
module softmax_over_channels_core #(
  parameter int MAX_CHANNELS = smx_pkg::MAX_CH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  smx_in_if.sink    in_ch,
  smx_out_if.source out_ch,
  smx_cfg_if.sink   cfg_ch
);
  import smx_pkg::*;

  logic      q_full;
  logic      q_push;
  logic      q_valid;
  logic      q_pop;
  col_desc_t q_data;
  col_desc_t q_head;
  score_wr_t wr;

  smx_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data),
    .wr     (wr)
  );

  smx_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head),
    .pop       (q_pop)
  );

  smx_back #(.MAX_CHANNELS(MAX_CHANNELS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
